// ===== rtl/spherical_dewarp_coordinate_generator_macros.svh =====
// Assertion macros for the dewarp coordinate generator
`ifndef SPHERICAL_DEWARP_COORDINATE_GENERATOR_MACROS_SVH
`define SPHERICAL_DEWARP_COORDINATE_GENERATOR_MACROS_SVH
`ifndef SYNTH
`define SDC_ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define SDC_ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SDC_ASSERT_IMPL(lbl, clk, rstn, prop)
`define SDC_ASSERT_RST(lbl, clk, rstn, prop)
`endif
`endif

// ===== rtl/sdc_pkg.sv =====
`timescale 1ns / 1ps
package sdc_pkg;
  typedef struct packed {
    logic [9:0] col_index;
    logic [9:0] row_index;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] source_x;
    logic signed [19:0] source_y;
  } out_item_t;

  typedef struct packed {
    logic [11:0]        center_x;
    logic [11:0]        center_y;
    logic [15:0]        radius_q4;
    logic [17:0]        half_edge_q8;
    logic [19:0]        plane_distance_q8;
    logic signed [17:0] angle_offset_x;
    logic signed [17:0] angle_offset_y;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_RADIUS    = 3'd2,
    REG_HALF_EDGE = 3'd3,
    REG_PLANE_DIST = 3'd4,
    REG_OFFSET_X  = 3'd5,
    REG_OFFSET_Y  = 3'd6
  } reg_idx_e;

  localparam int unsigned CORDIC_STEPS = 17;
  // vectoring datapath: x up to 2^30*1.65, y +-2^28
  localparam int unsigned VW = 33;
  localparam int unsigned AW = 20;
  localparam int unsigned RW = 20;
  localparam logic signed [AW-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [AW-1:0] PI_Q16      = 20'sd205887;
  localparam logic signed [RW-1:0] GAIN_INV_Q16 = 20'sd39797;
  localparam logic signed [19:0] OUT_MAX = 20'sd524287;
  localparam logic signed [19:0] OUT_MIN = -20'sd524288;

  function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
    logic signed [AW-1:0] r;
    begin
      case (i)
        5'd0:  r = 20'sd51472;
        5'd1:  r = 20'sd30386;
        5'd2:  r = 20'sd16055;
        5'd3:  r = 20'sd8150;
        5'd4:  r = 20'sd4091;
        5'd5:  r = 20'sd2047;
        5'd6:  r = 20'sd1024;
        5'd7:  r = 20'sd512;
        5'd8:  r = 20'sd256;
        5'd9:  r = 20'sd128;
        5'd10: r = 20'sd64;
        5'd11: r = 20'sd32;
        5'd12: r = 20'sd16;
        5'd13: r = 20'sd8;
        5'd14: r = 20'sd4;
        5'd15: r = 20'sd2;
        5'd16: r = 20'sd1;
        default: r = 20'sd0;
      endcase
      return r;
    end
  endfunction
endpackage

// ===== rtl/sdc_vec_stage.sv =====
`timescale 1ns / 1ps
// One vectoring CORDIC step for both axes (atan of t / dist)
module sdc_vec_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [sdc_pkg::VW-1:0] xa_i,
  input  logic signed [sdc_pkg::VW-1:0] ya_i,
  input  logic signed [sdc_pkg::AW-1:0] za_i,
  input  logic signed [sdc_pkg::VW-1:0] xb_i,
  input  logic signed [sdc_pkg::VW-1:0] yb_i,
  input  logic signed [sdc_pkg::AW-1:0] zb_i,
  output logic signed [sdc_pkg::VW-1:0] xa_o,
  output logic signed [sdc_pkg::VW-1:0] ya_o,
  output logic signed [sdc_pkg::AW-1:0] za_o,
  output logic signed [sdc_pkg::VW-1:0] xb_o,
  output logic signed [sdc_pkg::VW-1:0] yb_o,
  output logic signed [sdc_pkg::AW-1:0] zb_o
);
  localparam logic signed [sdc_pkg::AW-1:0] T = sdc_pkg::atan_tab(5'(STEP));
  logic signed [sdc_pkg::VW-1:0] xa_d, ya_d, xb_d, yb_d;
  logic signed [sdc_pkg::AW-1:0] za_d, zb_d;
  logic signed [sdc_pkg::VW-1:0] xa_q, ya_q, xb_q, yb_q;
  logic signed [sdc_pkg::AW-1:0] za_q, zb_q;

  always_comb begin
    if (!ya_i[sdc_pkg::VW-1]) begin
      xa_d = xa_i + (ya_i >>> STEP);
      ya_d = ya_i - (xa_i >>> STEP);
      za_d = za_i + T;
    end else begin
      xa_d = xa_i - (ya_i >>> STEP);
      ya_d = ya_i + (xa_i >>> STEP);
      za_d = za_i - T;
    end
    if (!yb_i[sdc_pkg::VW-1]) begin
      xb_d = xb_i + (yb_i >>> STEP);
      yb_d = yb_i - (xb_i >>> STEP);
      zb_d = zb_i + T;
    end else begin
      xb_d = xb_i - (yb_i >>> STEP);
      yb_d = yb_i + (xb_i >>> STEP);
      zb_d = zb_i - T;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q <= xa_d; ya_q <= ya_d; za_q <= za_d;
      xb_q <= xb_d; yb_q <= yb_d; zb_q <= zb_d;
    end
  end

  assign xa_o = xa_q;
  assign ya_o = ya_q;
  assign za_o = za_q;
  assign xb_o = xb_q;
  assign yb_o = yb_q;
  assign zb_o = zb_q;
endmodule

// ===== rtl/sdc_rot_stage.sv =====
`timescale 1ns / 1ps
// One rotation CORDIC step for both axes (sine)
module sdc_rot_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [sdc_pkg::RW-1:0] xa_i,
  input  logic signed [sdc_pkg::RW-1:0] ya_i,
  input  logic signed [sdc_pkg::AW-1:0] za_i,
  input  logic signed [sdc_pkg::RW-1:0] xb_i,
  input  logic signed [sdc_pkg::RW-1:0] yb_i,
  input  logic signed [sdc_pkg::AW-1:0] zb_i,
  output logic signed [sdc_pkg::RW-1:0] xa_o,
  output logic signed [sdc_pkg::RW-1:0] ya_o,
  output logic signed [sdc_pkg::AW-1:0] za_o,
  output logic signed [sdc_pkg::RW-1:0] xb_o,
  output logic signed [sdc_pkg::RW-1:0] yb_o,
  output logic signed [sdc_pkg::AW-1:0] zb_o
);
  localparam logic signed [sdc_pkg::AW-1:0] T = sdc_pkg::atan_tab(5'(STEP));
  logic signed [sdc_pkg::RW-1:0] xa_d, ya_d, xb_d, yb_d;
  logic signed [sdc_pkg::AW-1:0] za_d, zb_d;
  logic signed [sdc_pkg::RW-1:0] xa_q, ya_q, xb_q, yb_q;
  logic signed [sdc_pkg::AW-1:0] za_q, zb_q;

  always_comb begin
    if (!za_i[sdc_pkg::AW-1]) begin
      xa_d = xa_i - (ya_i >>> STEP);
      ya_d = ya_i + (xa_i >>> STEP);
      za_d = za_i - T;
    end else begin
      xa_d = xa_i + (ya_i >>> STEP);
      ya_d = ya_i - (xa_i >>> STEP);
      za_d = za_i + T;
    end
    if (!zb_i[sdc_pkg::AW-1]) begin
      xb_d = xb_i - (yb_i >>> STEP);
      yb_d = yb_i + (xb_i >>> STEP);
      zb_d = zb_i - T;
    end else begin
      xb_d = xb_i + (yb_i >>> STEP);
      yb_d = yb_i - (xb_i >>> STEP);
      zb_d = zb_i + T;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q <= xa_d; ya_q <= ya_d; za_q <= za_d;
      xb_q <= xb_d; yb_q <= yb_d; zb_q <= zb_d;
    end
  end

  assign xa_o = xa_q;
  assign ya_o = ya_q;
  assign za_o = za_q;
  assign xb_o = xb_q;
  assign yb_o = yb_q;
  assign zb_o = zb_q;
endmodule

// ===== rtl/spherical_dewarp_coordinate_generator.sv =====
`timescale 1ns / 1ps
// Stages from input transaction to result: prep, 17 atan steps, fold, 17 sine
// steps, scale multiply, output register. Throughput: one item per cycle, unless the output stalls.
// The whole pipeline advances together; a stall on the output freezes every stage.
// Reset: asynchronous, clears stage valid bits and loads register reset values
// (plane distance 256, everything else 0).
`include "spherical_dewarp_coordinate_generator_macros.svh"
module spherical_dewarp_coordinate_generator #(
  parameter int unsigned MAX_EDGE = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdc_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdc_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  localparam int unsigned NS = sdc_pkg::CORDIC_STEPS;
  localparam int unsigned DEPTH = 2 * NS + 4;
  localparam int unsigned VW = sdc_pkg::VW;
  localparam int unsigned AW = sdc_pkg::AW;
  localparam int unsigned RW = sdc_pkg::RW;

  sdc_pkg::cfg_t cfg_q;
  logic [DEPTH-1:0] vld_q;
  logic adv;

  // output register is the last stage; pipeline moves when its output is free
  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{plane_distance_q8: 20'd256, default: '0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sdc_pkg::REG_CENTER_X:   cfg_q.center_x <= cfg_data_i[11:0];
        sdc_pkg::REG_CENTER_Y:   cfg_q.center_y <= cfg_data_i[11:0];
        sdc_pkg::REG_RADIUS:     cfg_q.radius_q4 <= cfg_data_i[15:0];
        sdc_pkg::REG_HALF_EDGE:  cfg_q.half_edge_q8 <= cfg_data_i[17:0];
        sdc_pkg::REG_PLANE_DIST: cfg_q.plane_distance_q8 <= cfg_data_i[19:0];
        sdc_pkg::REG_OFFSET_X:   cfg_q.angle_offset_x <= cfg_data_i[17:0];
        sdc_pkg::REG_OFFSET_Y:   cfg_q.angle_offset_y <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // ---- stage 0: clamp index, form vectoring start vector
  logic [9:0] col_c, row_c;
  logic signed [VW-1:0] x0_d, ya0_d, yb0_d;
  logic signed [VW-1:0] x0_q, ya0_q, yb0_q;
  logic [19:0] dist_c;
  logic signed [18:0] ta_c, tb_c;

  always_comb begin
    col_c = (in_data_i.col_index >= 10'(MAX_EDGE - 1) && MAX_EDGE <= 1024)
            ? 10'(MAX_EDGE - 1) : in_data_i.col_index;
    row_c = (in_data_i.row_index >= 10'(MAX_EDGE - 1) && MAX_EDGE <= 1024)
            ? 10'(MAX_EDGE - 1) : in_data_i.row_index;
    if (MAX_EDGE > 1024) begin
      col_c = in_data_i.col_index;
      row_c = in_data_i.row_index;
    end
    dist_c = (cfg_q.plane_distance_q8 == '0) ? 20'd1 : cfg_q.plane_distance_q8;
    ta_c = $signed({1'b0, cfg_q.half_edge_q8}) - $signed({1'b0, col_c, 8'd0});
    tb_c = $signed({1'b0, cfg_q.half_edge_q8}) - $signed({1'b0, row_c, 8'd0});
    x0_d  = VW'({1'b0, dist_c, 10'd0});
    ya0_d = VW'(ta_c) <<< 10;
    yb0_d = VW'(tb_c) <<< 10;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= x0_d; ya0_q <= ya0_d; yb0_q <= yb0_d;
    end
  end

  // ---- atan chain
  logic signed [VW-1:0] vxa [NS+1];
  logic signed [VW-1:0] vya [NS+1];
  logic signed [AW-1:0] vza [NS+1];
  logic signed [VW-1:0] vxb [NS+1];
  logic signed [VW-1:0] vyb [NS+1];
  logic signed [AW-1:0] vzb [NS+1];
  assign vxa[0] = x0_q; assign vya[0] = ya0_q; assign vza[0] = '0;
  assign vxb[0] = x0_q; assign vyb[0] = yb0_q; assign vzb[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_vec
    sdc_vec_stage #(.STEP(i)) u_vec (
      .clk_i, .en_i(adv),
      .xa_i(vxa[i]), .ya_i(vya[i]), .za_i(vza[i]),
      .xb_i(vxb[i]), .yb_i(vyb[i]), .zb_i(vzb[i]),
      .xa_o(vxa[i+1]), .ya_o(vya[i+1]), .za_o(vza[i+1]),
      .xb_o(vxb[i+1]), .yb_o(vyb[i+1]), .zb_o(vzb[i+1])
    );
  end

  // ---- fold stage
  logic signed [AW-1:0] aa, ab, fa_d, fb_d, fa_q, fb_q;
  always_comb begin
    aa = vza[NS] + AW'(cfg_q.angle_offset_x);
    ab = vzb[NS] + AW'(cfg_q.angle_offset_y);
    fa_d = aa;
    fb_d = ab;
    if (aa > sdc_pkg::HALF_PI_Q16) fa_d = sdc_pkg::PI_Q16 - aa;
    if (aa < -sdc_pkg::HALF_PI_Q16) fa_d = -sdc_pkg::PI_Q16 - aa;
    if (ab > sdc_pkg::HALF_PI_Q16) fb_d = sdc_pkg::PI_Q16 - ab;
    if (ab < -sdc_pkg::HALF_PI_Q16) fb_d = -sdc_pkg::PI_Q16 - ab;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fa_q <= fa_d; fb_q <= fb_d;
    end
  end

  // ---- sine chain
  logic signed [RW-1:0] rxa [NS+1];
  logic signed [RW-1:0] rya [NS+1];
  logic signed [AW-1:0] rza [NS+1];
  logic signed [RW-1:0] rxb [NS+1];
  logic signed [RW-1:0] ryb [NS+1];
  logic signed [AW-1:0] rzb [NS+1];
  assign rxa[0] = sdc_pkg::GAIN_INV_Q16; assign rya[0] = '0; assign rza[0] = fa_q;
  assign rxb[0] = sdc_pkg::GAIN_INV_Q16; assign ryb[0] = '0; assign rzb[0] = fb_q;

  for (genvar i = 0; i < NS; i++) begin : g_rot
    sdc_rot_stage #(.STEP(i)) u_rot (
      .clk_i, .en_i(adv),
      .xa_i(rxa[i]), .ya_i(rya[i]), .za_i(rza[i]),
      .xb_i(rxb[i]), .yb_i(ryb[i]), .zb_i(rzb[i]),
      .xa_o(rxa[i+1]), .ya_o(rya[i+1]), .za_o(rza[i+1]),
      .xb_o(rxb[i+1]), .yb_o(ryb[i+1]), .zb_o(rzb[i+1])
    );
  end

  // ---- scale by radius
  logic signed [37:0] pa_d, pb_d, pa_q, pb_q;
  assign pa_d = $signed({1'b0, cfg_q.radius_q4}) * 38'(rya[NS]) + 38'sd32768;
  assign pb_d = $signed({1'b0, cfg_q.radius_q4}) * 38'(ryb[NS]) + 38'sd32768;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q <= pa_d; pb_q <= pb_d;
    end
  end

  // ---- add center, saturate
  logic signed [23:0] sx, sy;
  sdc_pkg::out_item_t out_d, out_q;
  always_comb begin
    sx = $signed({8'd0, cfg_q.center_x, 4'd0}) + 24'(pa_q >>> 16);
    sy = $signed({8'd0, cfg_q.center_y, 4'd0}) - 24'(pb_q >>> 16);
    out_d.source_x = (sx > 24'(sdc_pkg::OUT_MAX)) ? sdc_pkg::OUT_MAX :
                     (sx < 24'(sdc_pkg::OUT_MIN)) ? sdc_pkg::OUT_MIN : sx[19:0];
    out_d.source_y = (sy > 24'(sdc_pkg::OUT_MAX)) ? sdc_pkg::OUT_MAX :
                     (sy < 24'(sdc_pkg::OUT_MIN)) ? sdc_pkg::OUT_MIN : sy[19:0];
  end
  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = vld_q[DEPTH-1];
  assign out_data_o  = out_q;

  `SDC_ASSERT_IMPL(a_stall_holds_pipe, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> $stable(vld_q))
  `SDC_ASSERT_IMPL(a_in_stall_follows_out, clk_i, rst_ni, in_stall_o == (out_valid_o && out_stall_i))
  `SDC_ASSERT_RST(a_reset_empty, clk_i, rst_ni, !rst_ni |-> vld_q == '0)
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int PIPE_LAT  = 38;
  localparam int NUM_RAND  = 1100;
  localparam int MAX_CYC   = 400000;
  localparam int EDGE_LIM  = 1024;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  sdc_pkg::in_item_t   in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  sdc_pkg::out_item_t  out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i;
  logic [31:0]         cfg_data_i;

  spherical_dewarp_coordinate_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow copy of the block's registers
  logic [11:0]        sh_cx, sh_cy;
  logic [15:0]        sh_radius;
  logic [17:0]        sh_half;
  logic [19:0]        sh_dist;
  logic signed [17:0] sh_offx, sh_offy;

  sdc_pkg::out_item_t coord_q[$];
  int        mismatches;
  int        results_seen;
  int        cycle_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_cycles;
  bit        check_directed;

  typedef struct {
    int                 col;
    int                 row;
    bit                 has_exp;
    sdc_pkg::out_item_t exp_val;
  } dir_row_t;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_tab(int i);
    longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                      256, 128, 64, 32, 16, 8, 4, 2, 1};
    return t[i];
  endfunction

  function automatic longint view_sine(longint tq8, longint pdist, longint off);
    longint x, y, z, xs, ys, a;
    x = pdist * 1024;
    y = tq8 * 1024;
    z = 0;
    for (int i = 0; i < 17; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += arctan_tab(i);
      end else begin
        x -= ys; y += xs; z -= arctan_tab(i);
      end
    end
    a = z + off;
    if (a > 102944) a = 205887 - a;
    if (a < -102944) a = -205887 - a;
    x = 39797;
    y = 0;
    z = a;
    for (int i = 0; i < 17; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_tab(i);
      end else begin
        x += ys; y -= xs; z += arctan_tab(i);
      end
    end
    return y;
  endfunction

  function automatic longint radial_q4(int idx, longint off);
    longint pdist, t, s;
    pdist = sh_dist;
    if (pdist == 0) pdist = 1;
    if (idx >= EDGE_LIM) idx = EDGE_LIM - 1;
    t = longint'(sh_half) - longint'(idx) * 256;
    s = view_sine(t, pdist, off);
    return fshift(longint'(sh_radius) * s + 32768, 16);
  endfunction

  function automatic logic signed [19:0] clip_q4(longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  function automatic sdc_pkg::out_item_t predict_coord(int col, int row);
    sdc_pkg::out_item_t r;
    r.source_x = clip_q4(longint'(sh_cx) * 16 + radial_q4(col, longint'(sh_offx)));
    r.source_y = clip_q4(longint'(sh_cy) * 16 - radial_q4(row, longint'(sh_offy)));
    return r;
  endfunction

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYC) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: stall pattern, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sdc_pkg::out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (coord_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: x=%0d y=%0d", out_data_o.source_x,
                   out_data_o.source_y);
      end else begin
        e = coord_q.pop_front();
        if (e.source_x !== out_data_o.source_x || e.source_y !== out_data_o.source_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d", e.source_x,
                     e.source_y, out_data_o.source_x, out_data_o.source_y);
        end
      end
    end
  end

  task automatic write_reg(sdc_pkg::reg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      sdc_pkg::REG_CENTER_X:   sh_cx     = val[11:0];
      sdc_pkg::REG_CENTER_Y:   sh_cy     = val[11:0];
      sdc_pkg::REG_RADIUS:     sh_radius = val[15:0];
      sdc_pkg::REG_HALF_EDGE:  sh_half   = val[17:0];
      sdc_pkg::REG_PLANE_DIST: sh_dist   = val[19:0];
      sdc_pkg::REG_OFFSET_X:   sh_offx   = val[17:0];
      sdc_pkg::REG_OFFSET_Y:   sh_offy   = val[17:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(int col, int row, bit has_exp, sdc_pkg::out_item_t exp_val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i.col_index <= col[9:0];
    in_data_i.row_index <= row[9:0];
    coord_q.insert(coord_q.size(), has_exp ? exp_val : predict_coord(col, row));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (coord_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 5) @(posedge clk_i);
  endtask

  task automatic random_views(int n);
    int c, r;
    for (int k = 0; k < n; k++) begin
      // mostly realistic sizes, sometimes any value
      c = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(511);
      r = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(511);
      send_pixel(c, r, 1'b0, '0);
    end
  endtask

  task automatic random_config();
    write_reg(sdc_pkg::REG_CENTER_X, $urandom());
    write_reg(sdc_pkg::REG_CENTER_Y, $urandom());
    write_reg(sdc_pkg::REG_RADIUS, $urandom());
    write_reg(sdc_pkg::REG_HALF_EDGE,
              ($urandom_range(3) == 0) ? $urandom() : $urandom_range(131072));
    write_reg(sdc_pkg::REG_PLANE_DIST, ($urandom_range(7) == 0) ? $urandom() :
              $urandom_range(200000, 16));
    write_reg(sdc_pkg::REG_OFFSET_X, $urandom());
    write_reg(sdc_pkg::REG_OFFSET_Y, $urandom());
  endtask

  initial begin
    dir_row_t dir_tab[$];
    dir_row_t d;
    rst_ni        <= 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    mismatches    = 0;
    results_seen  = 0;
    cycle_cnt     = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles   = 0;
    sh_cx = '0; sh_cy = '0; sh_radius = '0; sh_half = '0; sh_dist = 20'd256;
    sh_offx = '0; sh_offy = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: zero radius and center, so every result is zero
    dir_tab.insert(dir_tab.size(), '{0, 0, 1'b1, '0});
    dir_tab.insert(dir_tab.size(), '{1023, 1023, 1'b1, '0});
    dir_tab.insert(dir_tab.size(), '{512, 7, 1'b1, '0});
    foreach (dir_tab[i]) send_pixel(dir_tab[i].col, dir_tab[i].row, 1'b1, dir_tab[i].exp_val);
    drain();

    // zero radius gives the center exactly
    write_reg(sdc_pkg::REG_CENTER_X, 32'd4095);
    write_reg(sdc_pkg::REG_CENTER_Y, 32'd100);
    dir_tab.delete();
    d.col = 5; d.row = 1000; d.has_exp = 1'b1;
    d.exp_val.source_x = 20'sd65520; d.exp_val.source_y = 20'sd1600;
    dir_tab.insert(dir_tab.size(), d);
    foreach (dir_tab[i]) send_pixel(dir_tab[i].col, dir_tab[i].row, 1'b1, dir_tab[i].exp_val);
    drain();
    // extremes of geometry, checked by the predictor
    write_reg(sdc_pkg::REG_RADIUS, 32'hFFFF);
    write_reg(sdc_pkg::REG_HALF_EDGE, 32'd131072);
    write_reg(sdc_pkg::REG_PLANE_DIST, 32'd0);           // zero distance treated as one
    write_reg(sdc_pkg::REG_OFFSET_X, 32'h3FFFF & 32'd102944);
    write_reg(sdc_pkg::REG_OFFSET_Y, 32'h3FFFF & (-32'sd102944));
    send_pixel(0, 0, 1'b0, '0);
    send_pixel(1023, 1023, 1'b0, '0);
    send_pixel(512, 511, 1'b0, '0);
    send_pixel(682, 341, 1'b0, '0);
    drain();
    // beyond-range offsets and half edge, fold and saturation
    write_reg(sdc_pkg::REG_HALF_EDGE, 32'h3FFFF);
    write_reg(sdc_pkg::REG_OFFSET_X, 32'h1FFFF);
    write_reg(sdc_pkg::REG_OFFSET_Y, 32'h20000);
    write_reg(sdc_pkg::REG_PLANE_DIST, 32'hFFFFF);
    write_reg(sdc_pkg::REG_CENTER_X, 32'd0);
    send_pixel(0, 1023, 1'b0, '0);
    send_pixel(1023, 0, 1'b0, '0);
    drain();
    write_reg(sdc_pkg::REG_PLANE_DIST, 32'd1);
    send_pixel(300, 700, 1'b0, '0);
    send_pixel(1023, 1023, 1'b0, '0);
    drain();

    // random phases over several idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      random_config();
      if (ph == 0) hold_cycles = 200;  // pipeline fills and backs up the input
      random_views(NUM_RAND / 4);
      drain();
    end

    $display("covered reset values, register extremes, offset fold, saturation, %0d results",
             results_seen);
    $display("idling phases: none, sender 78%%, receiver 78%%, both 11%%, plus a long hold-off");
    if (mismatches == 0 && coord_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("mismatches: %0d, left over: %0d", mismatches, coord_q.size());
      $display("FAIL");
    end
    $finish;
  end
endmodule
